[design/mvod_pkg.sv]
// Package for the motion-vector neighbour outlier detector.
// Holds geometry limits, field widths, register indexes and line-buffer types.
// No dependencies.
package mvod_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int STORE_DEPTH = 2 * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int POS_W   = 9;
    localparam int GEOM_W  = 10;
    localparam int VEC_W   = 16;
    localparam int WORD_W  = 2 * VEC_W;
    localparam int SQ_W    = 2 * VEC_W;
    localparam int DEV_W   = 33;
    localparam int CNT_W   = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [GEOM_W-1:0] RST_FRAME_WIDTH  = GEOM_W'(120);
    localparam logic [GEOM_W-1:0] RST_FRAME_HEIGHT = GEOM_W'(68);
    localparam logic [DEV_W-1:0]  RST_THRESHOLD    = DEV_W'(256);
    localparam logic [CNT_W-1:0]  RST_MAX_OUTLIERS = CNT_W'(1024);

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2,
        REG_MAX_OUTLIERS = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] ctr;
        logic [ADDR_W-1:0] lft;
        logic [ADDR_W-1:0] rgt;
    } t_rd_addr;

    typedef struct packed {
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] ctr;
        logic [WORD_W-1:0] lft;
        logic [WORD_W-1:0] rgt;
    } t_rd_data;

    // line-buffer slot of a column in the half chosen by row parity
    function automatic logic [ADDR_W-1:0] slot(input logic parity,
                                               input logic [GEOM_W-1:0] col);
        logic [ADDR_W:0] s;
        s = (ADDR_W+1)'(parity ? MAX_WIDTH : 0) + (ADDR_W+1)'(col);
        if (s >= (ADDR_W+1)'(STORE_DEPTH)) begin
            s = s - (ADDR_W+1)'(STORE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

[design/mvod_if.sv]
// Stream interfaces for the outlier detector: vector beats in, outlier beats out.
// Depends on mvod_pkg.
interface mvod_in_if import mvod_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;

    modport source (output valid, vec_x, vec_y, input ready);
    modport sink   (input valid, vec_x, vec_y, output ready);
endinterface

interface mvod_out_if import mvod_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] col_index;
    logic [POS_W-1:0] row_index;
    logic [DEV_W-1:0] sq_dev;

    modport source (output valid, col_index, row_index, sq_dev, input ready);
    modport sink   (input valid, col_index, row_index, sq_dev, output ready);
endinterface

[design/mvod_line_buf.sv]
// Two-row line buffer: two copies of the store, each with two read ports.
// Reads are registered and return the old word on a same-address write.
// Depends on mvod_pkg.
module mvod_line_buf import mvod_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  t_rd_addr          i_rd_addr,
    output t_rd_data          o_rd_data
);

    logic [WORD_W-1:0] r_mem_a [STORE_DEPTH];
    logic [WORD_W-1:0] r_mem_b [STORE_DEPTH];
    t_rd_data          r_rd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
            r_mem_b[i_wr_addr] <= i_wr_data;
            r_rd.top <= r_mem_a[i_rd_addr.top];
            r_rd.ctr <= r_mem_a[i_rd_addr.ctr];
            r_rd.lft <= r_mem_b[i_rd_addr.lft];
            r_rd.rgt <= r_mem_b[i_rd_addr.rgt];
        end
    end

    assign o_rd_data = r_rd;

endmodule

[design/mv_neighbour_outlier_detect.sv]
// Top level of the motion-vector neighbour outlier detector.
// Depends on mvod_pkg, mvod_if and mvod_line_buf.
//
//  channel   dir  beat                                  handshake
//  i_vec     in   vec_x, vec_y                          valid/ready
//  o_res     out  col_index, row_index, sq_dev          valid/ready
//  apb       in   frame_width, frame_height, threshold,  psel/penable/pwrite
//                 max_outliers at 0x00/0x08/0x10/0x18
//
// One vector beat per cycle unless a held outlier stalls; line-buffer words
// are read into the input register at the edge that accepts the bottom
// neighbour, and an outlier moves on to the output register (average, square,
// sum and compare in one pass). The line buffer's two copies serve the four
// reads. Reset clears positions, count and stage valids; the line buffer is
// not cleared. A held outlier on o_res stalls the input register, then i_vec.
module mv_neighbour_outlier_detect import mvod_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mvod_in_if.sink            i_vec,
    mvod_out_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    function automatic logic signed [VEC_W:0] dev_comp(
        input logic signed [VEC_W-1:0] c,
        input logic signed [VEC_W-1:0] a,
        input logic signed [VEC_W-1:0] b,
        input logic signed [VEC_W-1:0] t,
        input logic signed [VEC_W-1:0] v
    );
        logic signed [VEC_W+1:0] s;
        logic signed [VEC_W+1:0] q;
        s = (VEC_W+2)'(a) + (VEC_W+2)'(b) + (VEC_W+2)'(t) + (VEC_W+2)'(v);
        if (s < 0) begin
            s = s + (VEC_W+2)'(3);
        end
        q = s >>> 2;
        return (VEC_W+1)'(c) - (VEC_W+1)'($signed(q[VEC_W-1:0]));
    endfunction

    logic [GEOM_W-1:0] r_frame_width;
    logic [GEOM_W-1:0] r_frame_height;
    logic [DEV_W-1:0]  r_threshold;
    logic [CNT_W-1:0]  r_max_outliers;

    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_found;

    logic [GEOM_W-1:0] w_eff;
    logic [GEOM_W-1:0] h_eff;
    logic [GEOM_W-1:0] col_nx;
    logic [GEOM_W-1:0] row_nx;
    logic              wrap_col;
    logic              wrap_row;
    logic              interior;
    logic [POS_W-1:0]  n_col;
    logic [POS_W-1:0]  n_row;

    t_rd_addr          rd_addr;
    t_rd_data          rd_data;
    logic [ADDR_W-1:0] wr_addr;

    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    logic              in_rdy;
    logic              in_acc;
    logic              out_free;
    logic              s1_adv;

    logic                    r_s1_valid;
    logic signed [VEC_W-1:0] r_s1_x;
    logic signed [VEC_W-1:0] r_s1_y;
    logic [POS_W-1:0]        r_s1_col;
    logic [POS_W-1:0]        r_s1_row;
    logic                    r_s1_int;
    logic                    r_s1_end;

    logic signed [VEC_W:0]   dev_x;
    logic signed [VEC_W:0]   dev_y;

    logic signed [2*VEC_W+1:0] sqx_full;
    logic signed [2*VEC_W+1:0] sqy_full;

    logic [DEV_W-1:0]        dev;
    logic                    emit;

    logic                    r_out_valid;
    logic [POS_W-1:0]        r_out_col;
    logic [POS_W-1:0]        r_out_row;
    logic [DEV_W-1:0]        r_out_dev;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_threshold    <= RST_THRESHOLD;
            r_max_outliers <= RST_MAX_OUTLIERS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[GEOM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[GEOM_W-1:0];
                REG_THRESHOLD:    r_threshold    <= pwdata[DEV_W-1:0];
                REG_MAX_OUTLIERS: r_max_outliers <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            REG_THRESHOLD:    prdata = PDATA_W'(r_threshold);
            REG_MAX_OUTLIERS: prdata = PDATA_W'(r_max_outliers);
            default:          prdata = '0;
        endcase
    end

    // handshake chain
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign in_rdy   = !r_s1_valid || s1_adv;
    assign in_acc   = i_vec.valid && in_rdy;
    assign i_vec.ready = in_rdy;

    // position and neighbourhood
    assign w_eff = (r_frame_width > GEOM_W'(MAX_WIDTH)) ? GEOM_W'(MAX_WIDTH) : r_frame_width;
    assign h_eff = (r_frame_height > GEOM_W'(MAX_HEIGHT)) ? GEOM_W'(MAX_HEIGHT)
                                                          : r_frame_height;
    assign col_nx   = GEOM_W'(r_col) + GEOM_W'(1);
    assign row_nx   = GEOM_W'(r_row) + GEOM_W'(1);
    assign wrap_col = col_nx >= w_eff;
    assign wrap_row = row_nx >= h_eff;
    assign interior = (w_eff >= GEOM_W'(3)) && (h_eff >= GEOM_W'(3))
                   && (r_row >= POS_W'(2)) && (GEOM_W'(r_row) < h_eff)
                   && (r_col >= POS_W'(1)) && (col_nx < w_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (wrap_col) begin
            n_col = '0;
            n_row = wrap_row ? '0 : row_nx[POS_W-1:0];
        end else begin
            n_col = col_nx[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign wr_addr     = slot(r_row[0], GEOM_W'(r_col));
    assign rd_addr.top = wr_addr;
    assign rd_addr.ctr = slot(~r_row[0], GEOM_W'(r_col));
    assign rd_addr.lft = slot(~r_row[0], GEOM_W'(r_col) - GEOM_W'(1));
    assign rd_addr.rgt = slot(~r_row[0], col_nx);

    mvod_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_en      (in_acc),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_vec.vec_y, i_vec.vec_x}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // input register: beat and line-buffer words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x   <= i_vec.vec_x;
            r_s1_y   <= i_vec.vec_y;
            r_s1_col <= r_col;
            r_s1_row <= r_row - POS_W'(1);
            r_s1_int <= interior;
            r_s1_end <= wrap_col && wrap_row;
        end
    end

    assign dev_x = dev_comp(rd_data.ctr[VEC_W-1:0], rd_data.lft[VEC_W-1:0],
                            rd_data.rgt[VEC_W-1:0], rd_data.top[VEC_W-1:0], r_s1_x);
    assign dev_y = dev_comp(rd_data.ctr[WORD_W-1:VEC_W], rd_data.lft[WORD_W-1:VEC_W],
                            rd_data.rgt[WORD_W-1:VEC_W], rd_data.top[WORD_W-1:VEC_W],
                            r_s1_y);

    assign sqx_full = dev_x * dev_x;
    assign sqy_full = dev_y * dev_y;

    assign dev  = DEV_W'(sqx_full[SQ_W-1:0]) + DEV_W'(sqy_full[SQ_W-1:0]);
    assign emit = r_s1_int && (r_found < r_max_outliers) && (dev >= r_threshold);

    // result register and per-frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_found     <= '0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1_end) begin
                    r_found <= '0;
                end else if (emit) begin
                    r_found <= r_found + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out_col <= r_s1_col;
            r_out_row <= r_s1_row;
            r_out_dev <= dev;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.col_index = r_out_col;
    assign o_res.row_index = r_out_row;
    assign o_res.sq_dev    = r_out_dev;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable({r_s1_x, r_s1_y, r_s1_col}))
        else $error("input register changed under a stall");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted beat lost before the input register");

    a_out_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.col_index != '0) && (o_res.row_index != '0))
        else $error("outlier reported on the frame border");

    a_emit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && emit |-> r_found < r_max_outliers)
        else $error("outlier issued past the per-frame limit");

endmodule
